@@ rtl/core/lqps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue priority scorer package
// Shared widths, operation and status codes, word layouts and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lqps_pkg;

  localparam int DEPTH_DEFAULT   = 256;
  localparam int ID_BITS_DEFAULT = 16;

  localparam int OPCODE_W    = 2;
  localparam int VID_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 8;
  localparam int WAIT_W      = 32;
  localparam int PRIO_W      = 28;
  localparam int CAP_W       = 8;
  localparam int BLOCK_W     = 9;
  localparam int FRAC_BITS   = 8;
  // Priority numerator: a 32-bit product scaled by 2^8.
  localparam int NUM_W       = WAIT_W + FRAC_BITS;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BLOCK_W;

  localparam logic [CFG_IDX_W-1:0] CFG_LANE_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKAGE      = 1'd1;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [PRIO_W-1:0]  EMERGENCY_SCORE = 28'd255999744;
  localparam logic [CAP_W-1:0]   CAPACITY_RESET  = 8'd16;
  localparam logic [BLOCK_W-1:0] FULL_BLOCK      = 9'd256;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VID_W-1:0]    vehicle_id;
    logic                is_emergency;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [VID_W-1:0]       removed_id;
    logic                   removed_emergency;
    logic [COUNT_OUT_W-1:0] queued_count;
    logic                   emergency_present;
    logic [WAIT_W-1:0]      wait_total;
    logic [WAIT_W-1:0]      wait_average;
    logic [PRIO_W-1:0]      lane_priority;
    logic [CAP_W-1:0]       usable_capacity;
    logic                   lane_blocked;
  } result_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fetch;
    logic start_prio;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/lqps_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue stream interface
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface lqps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lqps_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue serial divider
// Restoring divider producing two quotient bits per cycle over a fixed-width
// dividend; remainder and quotient stay stable after busy falls.
// ----------------------------------------------------------------------------
module lqps_divider #(
  parameter int DEN_W = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [lqps_pkg::NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]         den,
  output logic                          busy,
  output logic [lqps_pkg::NUM_W-1:0]    quotient,
  output logic [DEN_W-1:0]              remainder
);
  import lqps_pkg::*;

  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] quo_next;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_reg;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   t1;
  logic [DEN_W:0]   t2;
  logic [DEN_W-1:0] r1;
  logic [DEN_W-1:0] r2;
  logic             b1;
  logic             b2;

  // Two dependent shift-subtract steps per cycle.
  always_comb begin
    t1 = {rem, quo[NUM_W-1]};
    b1 = (t1 >= {1'b0, den_reg});
    r1 = b1 ? DEN_W'(t1 - {1'b0, den_reg}) : t1[DEN_W-1:0];
    t2 = {r1, quo[NUM_W-2]};
    b2 = (t2 >= {1'b0, den_reg});
    r2 = b2 ? DEN_W'(t2 - {1'b0, den_reg}) : t2[DEN_W-1:0];
    quo_next = {quo[NUM_W-3:0], b1, b2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      den_reg <= den;
      cnt     <= CNT_W'(STEPS - 1);
    end else if (busy) begin
      quo <= quo_next;
      rem <= r2;
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

@@ rtl/core/lqps_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue datapath
// Vehicle store, queue pointers and counters, waiting total, configuration
// registers, shared divider and the output word register.
// ----------------------------------------------------------------------------
module lqps_datapath #(
  parameter int QUEUE_DEPTH = lqps_pkg::DEPTH_DEFAULT,
  parameter int ID_BITS     = lqps_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lqps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lqps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire lqps_pkg::dp_cmd_t             cmd,
  output lqps_pkg::dp_status_t               stat,
  input  wire lqps_pkg::item_t               item_data,
  output lqps_pkg::result_t                  result_data,
  output logic                               result_valid,
  input  wire logic                          result_ready
);
  import lqps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Configuration and derived capacity.
  logic [CAP_W-1:0]         lane_capacity;
  logic [BLOCK_W-1:0]       blockage;
  logic [BLOCK_W-1:0]       blk_clamped;
  logic [CAP_W+BLOCK_W-1:0] cap_product;
  logic [CAP_W-1:0]         eff;

  // Latched item.
  logic [OPCODE_W-1:0] op_reg;
  logic [VID_W-1:0]    id_reg;
  logic                emg_reg;

  // Queue state.
  logic [ID_BITS:0]    store [QUEUE_DEPTH];
  logic [ID_BITS:0]    rd_entry;
  logic                rd_pending;
  logic [PTR_W-1:0]    head;
  logic [PTR_W-1:0]    tail;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ecount;
  logic [WAIT_W-1:0]   total;
  logic [WAIT_W:0]     tick_sum;
  logic                full;
  logic                empty;

  // Per-word results.
  logic [STATUS_W-1:0] status_reg;
  logic [VID_W-1:0]    rid;
  logic                remg;
  logic [WAIT_W-1:0]   avg;
  logic [PRIO_W-1:0]   prio_sel;

  // Divider hookup.
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [CMP_W-1:0]  div_den;
  logic              div_busy;
  logic [NUM_W-1:0]  div_quo;
  logic [CMP_W-1:0]  div_rem;
  logic [NUM_W-1:0]  prio_num;

  always_comb begin
    blk_clamped = (blockage > FULL_BLOCK) ? FULL_BLOCK : blockage;
    cap_product = (CAP_W+BLOCK_W)'(lane_capacity) * (CAP_W+BLOCK_W)'(FULL_BLOCK - blk_clamped);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_capacity <= CAPACITY_RESET;
      blockage      <= '0;
      eff           <= CAPACITY_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LANE_CAPACITY: lane_capacity <= cfg_data[CAP_W-1:0];
          CFG_BLOCKAGE:      blockage      <= cfg_data;
        endcase
      end
      eff <= cap_product[FRAC_BITS +: CAP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg  <= item_data.opcode;
      id_reg  <= item_data.vehicle_id;
      emg_reg <= item_data.is_emergency;
    end
  end

  assign full  = (CMP_W'(count) >= CMP_W'(eff)) || (count >= CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign tick_sum = {1'b0, total} + (WAIT_W+1)'(count);

  // Vehicle store: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk) begin
    if (cmd.exec && op_reg == OP_ADD && !full) begin
      store[tail] <= {ID_BITS'(id_reg), emg_reg};
    end
    if (cmd.exec && op_reg == OP_REMOVE && !empty) begin
      rd_entry <= store[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      ecount     <= '0;
      total      <= '0;
      rd_pending <= 1'b0;
    end else if (cmd.exec) begin
      rd_pending <= 1'b0;
      unique case (op_reg)
        OP_ADD: begin
          if (!full) begin
            tail   <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count  <= count + 1'b1;
            ecount <= ecount + CNT_W'(emg_reg);
          end
        end
        OP_REMOVE: begin
          if (!empty) begin
            head       <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count      <= count - 1'b1;
            rd_pending <= 1'b1;
          end
        end
        OP_TICK: begin
          total <= tick_sum[WAIT_W] ? '1 : tick_sum[WAIT_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (cmd.fetch) begin
      // The removed entry's emergency bit is known only once the read lands.
      if (rd_pending && rd_entry[0] && ecount != '0) begin
        ecount <= ecount - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      priority if (op_reg == OP_ADD && full) begin
        status_reg <= ST_FULL;
      end else if (op_reg == OP_REMOVE && empty) begin
        status_reg <= ST_EMPTY;
      end else begin
        status_reg <= ST_OK;
      end
    end
    if (cmd.fetch) begin
      rid  <= rd_pending ? VID_W'(rd_entry[ID_BITS:1]) : '0;
      remg <= rd_pending & rd_entry[0];
    end
    if (cmd.start_prio) begin
      avg <= empty ? '0 : div_quo[WAIT_W-1:0];
    end
  end

  // count * avg equals total minus the remainder of total / count.
  assign prio_num  = empty ? '0 : {total - WAIT_W'(div_rem), FRAC_BITS'(0)};
  assign div_start = cmd.fetch | cmd.start_prio;
  assign div_num   = cmd.fetch ? NUM_W'(total) : prio_num;
  assign div_den   = cmd.fetch ? CMP_W'(count) : CMP_W'(eff);

  lqps_divider #(
    .DEN_W (CMP_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .num       (div_num),
    .den       (div_den),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    priority if (eff == '0) begin
      prio_sel = '0;
    end else if (ecount != '0) begin
      prio_sel = EMERGENCY_SCORE;
    end else if (div_quo > NUM_W'(EMERGENCY_SCORE)) begin
      prio_sel = EMERGENCY_SCORE;
    end else begin
      prio_sel = div_quo[PRIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_data.status            <= status_reg;
      result_data.removed_id        <= rid;
      result_data.removed_emergency <= remg;
      result_data.queued_count      <= COUNT_OUT_W'(count);
      result_data.emergency_present <= (ecount != '0);
      result_data.wait_total        <= total;
      result_data.wait_average      <= avg;
      result_data.lane_priority     <= prio_sel;
      result_data.usable_capacity   <= eff;
      result_data.lane_blocked      <= (blockage != '0);
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_free = !result_valid || result_ready;

endmodule
`default_nettype wire

@@ rtl/core/lqps_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue controller
// Sequences one word: queue update, store read, average divide, priority
// divide and the output load.
// ----------------------------------------------------------------------------
module lqps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lqps_pkg::dp_status_t stat,
  output lqps_pkg::dp_cmd_t         cmd
);
  import lqps_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_FETCH    = 3'd2;
  localparam logic [2:0] S_DIV_AVG  = 3'd3;
  localparam logic [2:0] S_PRIO     = 3'd4;
  localparam logic [2:0] S_DIV_PRIO = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready       = (state == S_IDLE);
  assign cmd.accept     = in_ready && in_valid;
  assign cmd.exec       = (state == S_EXEC);
  assign cmd.fetch      = (state == S_FETCH);
  assign cmd.start_prio = (state == S_PRIO);
  assign cmd.load_out   = (state == S_FINISH) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_EXEC;
      S_EXEC:     state_next = S_FETCH;
      S_FETCH:    state_next = S_DIV_AVG;
      S_DIV_AVG:  if (!stat.div_busy) state_next = S_PRIO;
      S_PRIO:     state_next = S_DIV_PRIO;
      S_DIV_PRIO: if (!stat.div_busy) state_next = S_FINISH;
      S_FINISH:   if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lane_queue_priority_scorer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lane queue priority scorer
// Bounded vehicle queue with waiting statistics and a lane priority score.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of input words (add, remove or tick).
//   result : valid/ready channel, exactly one result word per input word.
//   cfg_*  : write-only registers; index 0 lane capacity, index 1 blockage.
//            Write them only while no word is in flight.
// Each word passes a queue update and a store read, then two serial divides
// (average, then priority) on one shared divider retiring two quotient bits
// per cycle over a 40-bit dividend. The next input word can be accepted in
// the cycle after the result is loaded.
// The result sits in an output register; the next word is accepted and worked
// on while it waits. If the receiver stalls, the following result holds in the
// last step until the output register frees up.
// Reset empties the queue, clears the waiting total and sets the lane
// capacity to 16 with no blockage. The vehicle store itself is not cleared.
// ----------------------------------------------------------------------------
module lane_queue_priority_scorer #(
  parameter int QUEUE_DEPTH = lqps_pkg::DEPTH_DEFAULT,
  parameter int ID_BITS     = lqps_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  lqps_stream_if.sink                          item,
  lqps_stream_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [lqps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lqps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lqps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  logic       in_ready;

  assign item.ready = in_ready;

  lqps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lqps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .item_data    (item.data),
    .result_data  (result.data),
    .result_valid (result.valid),
    .result_ready (result.ready)
  );

`ifndef SYNTH
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("output word loaded over an untaken word");

  a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !item.ready)
    else $error("input accepted while the divider is busy");

  a_empty_remove_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.status == ST_EMPTY) |->
      (result.data.removed_id == '0 && !result.data.removed_emergency))
    else $error("failed remove reports a vehicle");

  a_emergency_score: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.emergency_present &&
     result.data.usable_capacity != '0) |->
      (result.data.lane_priority == EMERGENCY_SCORE))
    else $error("emergency lane without emergency score");
`endif

endmodule
`default_nettype wire
